// File: sv/hrcd_pkg.sv
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types and character constants of the HTTP request completion detector.
// ----------------------------------------------------------------------------
package hrcd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam int unsigned LEN_NAME_LEN = 15;
  localparam int unsigned ENC_NAME_LEN = 18;
  localparam int unsigned CHUNK_WORD_LEN = 7;
  localparam int unsigned END_MARK_LEN = 4;
  localparam int unsigned CHUNK_END_LEN = 5;

  localparam int unsigned LEN_POS_W = $clog2(LEN_NAME_LEN + 1);
  localparam int unsigned ENC_POS_W = $clog2(ENC_NAME_LEN + 1);
  localparam int unsigned WORD_POS_W = $clog2(CHUNK_WORD_LEN + 1);
  localparam int unsigned END_POS_W = $clog2(END_MARK_LEN + 1);
  localparam int unsigned TERM_POS_W = $clog2(CHUNK_END_LEN + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [0:LEN_NAME_LEN-1][7:0] UPPER_LEN_NAME = "Content-Length:";
  localparam logic [0:LEN_NAME_LEN-1][7:0] LOWER_LEN_NAME = "content-length:";
  localparam logic [0:ENC_NAME_LEN-1][7:0] UPPER_ENC_NAME = "Transfer-Encoding:";
  localparam logic [0:ENC_NAME_LEN-1][7:0] LOWER_ENC_NAME = "transfer-encoding:";
  localparam logic [0:CHUNK_WORD_LEN-1][7:0] CHUNK_WORD = "chunked";
  localparam logic [0:END_MARK_LEN-1][7:0] END_MARK = {CH_CR, CH_LF, CH_CR, CH_LF};
  localparam logic [0:CHUNK_END_LEN-1][7:0] CHUNK_END = {CH_ZERO, CH_CR, CH_LF, CH_CR, CH_LF};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_DIGITS,
    PH_TRAIL,
    PH_INVALID,
    PH_DONE
  } hrcd_phase_e;

  // per-byte strobe to the header scanners
  typedef struct packed {
    logic       en;
    logic       clr;
    logic [7:0] data;
  } hrcd_step_t;

endpackage

// File: sv/hrcd_len_scan.sv
// ----------------------------------------------------------------------------
// hrcd_len_scan
// Content-Length field scanner for one spelling: name match and decimal value.
// ----------------------------------------------------------------------------
module hrcd_len_scan #(
  parameter int unsigned LENGTH_BITS = hrcd_pkg::LENGTH_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  hrcd_pkg::hrcd_step_t                         step_i,
  input  logic [0:hrcd_pkg::LEN_NAME_LEN-1][7:0]       name_i,
  output logic                                         seen_o,
  output logic [LENGTH_BITS-1:0]                       value_o
);
  import hrcd_pkg::*;

  logic                   seen_q, seen_d;
  logic [LEN_POS_W-1:0]   pos_q, pos_d;
  hrcd_phase_e            phase_q, phase_d;
  logic                   cr_q, cr_d;
  logic [LENGTH_BITS-1:0] value_q, value_d;
  logic [LENGTH_BITS+3:0] wide;
  logic [LENGTH_BITS-1:0] value_acc;
  logic [7:0]             b;

  assign b = step_i.data;

  // value * 10 + digit, saturating
  assign wide = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1)
              + (LENGTH_BITS + 4)'(b[3:0]);
  assign value_acc = (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) ? '1 : wide[LENGTH_BITS-1:0];

  always_comb begin
    logic                 line_end;
    logic [LEN_POS_W-1:0] pos_base;
    seen_d   = seen_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    cr_d     = cr_q;
    value_d  = value_q;
    line_end = 1'b0;
    pos_base = step_i.clr ? '0 : pos_q;
    if (step_i.clr) begin
      seen_d  = 1'b0;
      pos_d   = '0;
      phase_d = PH_IDLE;
      cr_d    = 1'b0;
      value_d = '0;
    end
    if (step_i.en) begin
      if (seen_d) begin
        if (phase_d != PH_DONE) begin
          if (cr_d) begin
            cr_d = 1'b0;
            if (b == CH_LF) begin
              if (phase_d != PH_DIGITS && phase_d != PH_TRAIL) value_d = '0;
              phase_d  = PH_DONE;
              line_end = 1'b1;
            end else begin
              phase_d = PH_INVALID;
            end
          end
          if (!line_end) begin
            if (b == CH_CR) begin
              cr_d = 1'b1;
            end else if (b == CH_SP || b == CH_TAB) begin
              if (phase_d == PH_DIGITS) phase_d = PH_TRAIL;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
              if (phase_d == PH_LEAD || phase_d == PH_DIGITS) begin
                phase_d = PH_DIGITS;
                value_d = value_acc;
              end else begin
                phase_d = PH_INVALID;
              end
            end else begin
              phase_d = PH_INVALID;
            end
          end
        end
      end else begin
        if (pos_base < LEN_POS_W'(LEN_NAME_LEN) && b == name_i[pos_base]) begin
          pos_d = pos_base + LEN_POS_W'(1);
        end else begin
          pos_d = (b == name_i[0]) ? LEN_POS_W'(1) : '0;
        end
        if (pos_d == LEN_POS_W'(LEN_NAME_LEN)) begin
          seen_d  = 1'b1;
          phase_d = PH_LEAD;
          value_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      pos_q   <= '0;
      phase_q <= PH_IDLE;
      cr_q    <= 1'b0;
      value_q <= '0;
    end else begin
      seen_q  <= seen_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      cr_q    <= cr_d;
      value_q <= value_d;
    end
  end

  assign seen_o  = seen_d;
  assign value_o = value_d;

endmodule

// File: sv/hrcd_enc_scan.sv
// ----------------------------------------------------------------------------
// hrcd_enc_scan
// Transfer-Encoding field scanner for one spelling: name match and chunked word.
// ----------------------------------------------------------------------------
module hrcd_enc_scan (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hrcd_pkg::hrcd_step_t                   step_i,
  input  logic [0:hrcd_pkg::ENC_NAME_LEN-1][7:0] name_i,
  output logic                                   seen_o,
  output logic                                   chunked_o
);
  import hrcd_pkg::*;

  logic                  seen_q, seen_d;
  logic [ENC_POS_W-1:0]  pos_q, pos_d;
  logic                  open_q, open_d;
  logic [WORD_POS_W-1:0] word_q, word_d;
  logic                  chunked_q, chunked_d;
  logic                  cr_q, cr_d;
  logic [7:0]            b;

  assign b = step_i.data;

  always_comb begin
    logic                  skip;
    logic [ENC_POS_W-1:0]  pos_base;
    logic [WORD_POS_W-1:0] word_base;
    seen_d    = seen_q;
    pos_d     = pos_q;
    open_d    = open_q;
    word_d    = word_q;
    chunked_d = chunked_q;
    cr_d      = cr_q;
    skip      = 1'b0;
    pos_base  = step_i.clr ? '0 : pos_q;
    if (step_i.clr) begin
      seen_d    = 1'b0;
      pos_d     = '0;
      open_d    = 1'b0;
      word_d    = '0;
      chunked_d = 1'b0;
      cr_d      = 1'b0;
    end
    word_base = word_d;
    if (step_i.en) begin
      if (seen_d) begin
        if (open_d) begin
          if (cr_d) begin
            cr_d = 1'b0;
            if (b == CH_LF) begin
              open_d = 1'b0;
              skip   = 1'b1;
            end
          end
          if (!skip) begin
            if (b == CH_CR) begin
              cr_d   = 1'b1;
              word_d = '0;
            end else begin
              if (word_base < WORD_POS_W'(CHUNK_WORD_LEN) && b == CHUNK_WORD[word_base]) begin
                word_d = word_base + WORD_POS_W'(1);
              end else begin
                word_d = (b == CHUNK_WORD[0]) ? WORD_POS_W'(1) : '0;
              end
              if (word_d == WORD_POS_W'(CHUNK_WORD_LEN)) begin
                chunked_d = 1'b1;
                word_d    = '0;
              end
            end
          end
        end
      end else begin
        if (pos_base < ENC_POS_W'(ENC_NAME_LEN) && b == name_i[pos_base]) begin
          pos_d = pos_base + ENC_POS_W'(1);
        end else begin
          pos_d = (b == name_i[0]) ? ENC_POS_W'(1) : '0;
        end
        if (pos_d == ENC_POS_W'(ENC_NAME_LEN)) begin
          seen_d = 1'b1;
          open_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      pos_q     <= '0;
      open_q    <= 1'b0;
      word_q    <= '0;
      chunked_q <= 1'b0;
      cr_q      <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      pos_q     <= pos_d;
      open_q    <= open_d;
      word_q    <= word_d;
      chunked_q <= chunked_d;
      cr_q      <= cr_d;
    end
  end

  assign seen_o    = seen_d;
  assign chunked_o = chunked_d;

endmodule

// File: sv/http_request_completion_detector.sv
// ----------------------------------------------------------------------------
// http_request_completion_detector
// Scans a request one byte per transfer and reports header end, body length
// and completion of the request.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                         tuser
// s_axis    in   [7:0] data_byte                               [0] new_request
// m_axis    out  [0] headers_complete [1] request_complete     -
//                [2] chunked_mode [34:3] declared_length
//                [66:35] body_count (zero-padded to 72 bits)
//
// One byte per cycle sustained unless the output stalls, as the field scanners
// update their state once per byte; results leave through the result register.
// Reset clears all scanner and request state; no clearing pass.
// While the result register is stalled, one further byte is held in the
// input register.
// ----------------------------------------------------------------------------
module http_request_completion_detector #(
  parameter int unsigned LENGTH_BITS = hrcd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] new_request
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [0] headers_complete, [1] request_complete,
                                        // [2] chunked_mode, [34:3] declared_length,
                                        // [66:35] body_count, [71:67] zero
);
  import hrcd_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_data_q;
  logic       in_new_q;
  logic       advance, consume, s_fire;

  // request state
  logic [END_POS_W-2:0]   hdr_prog_q, hdr_prog_d;
  logic                   hdr_done_q, hdr_done_d;
  logic [LENGTH_BITS-1:0] body_q, body_d;
  logic [TERM_POS_W-1:0]  term_q, term_d;
  logic                   done_q, done_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [66:0] out_data_q;

  hrcd_step_t             step;
  logic                   len_seen_u, len_seen_l, enc_seen_u, enc_seen_l;
  logic                   enc_chunk_u, enc_chunk_l;
  logic [LENGTH_BITS-1:0] len_val_u, len_val_l;
  logic                   sel_chunked;
  logic [LENGTH_BITS-1:0] sel_len;
  logic [LENGTH_BITS-1:0] out_len;
  logic [LENGTH_BITS+31:0] len_ext, body_ext;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign consume         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  assign step.clr  = consume && in_new_q;
  assign step.en   = consume && (in_new_q || !hdr_done_q);
  assign step.data = in_data_q;

  hrcd_len_scan #(.LENGTH_BITS(LENGTH_BITS)) u_len_upper (
    .clk_i, .rst_ni, .step_i(step), .name_i(UPPER_LEN_NAME),
    .seen_o(len_seen_u), .value_o(len_val_u)
  );

  hrcd_len_scan #(.LENGTH_BITS(LENGTH_BITS)) u_len_lower (
    .clk_i, .rst_ni, .step_i(step), .name_i(LOWER_LEN_NAME),
    .seen_o(len_seen_l), .value_o(len_val_l)
  );

  hrcd_enc_scan u_enc_upper (
    .clk_i, .rst_ni, .step_i(step), .name_i(UPPER_ENC_NAME),
    .seen_o(enc_seen_u), .chunked_o(enc_chunk_u)
  );

  hrcd_enc_scan u_enc_lower (
    .clk_i, .rst_ni, .step_i(step), .name_i(LOWER_ENC_NAME),
    .seen_o(enc_seen_l), .chunked_o(enc_chunk_l)
  );

  // capitalised spelling wins
  assign sel_chunked = enc_seen_u ? enc_chunk_u : (enc_seen_l && enc_chunk_l);
  assign sel_len     = len_seen_u ? len_val_u : (len_seen_l ? len_val_l : '0);

  always_comb begin
    logic [END_POS_W-2:0]  prog_base;
    logic [END_POS_W-1:0]  prog_n;
    logic [TERM_POS_W-1:0] term_n;
    hdr_prog_d = hdr_prog_q;
    hdr_done_d = hdr_done_q;
    body_d     = body_q;
    term_d     = term_q;
    done_d     = done_q;
    prog_base  = '0;
    prog_n     = '0;
    term_n     = '0;
    if (consume) begin
      if (in_new_q) begin
        hdr_prog_d = '0;
        hdr_done_d = 1'b0;
        body_d     = '0;
        term_d     = '0;
        done_d     = 1'b0;
      end
      prog_base = hdr_prog_d;
      if (!hdr_done_d) begin
        if (in_data_q == END_MARK[prog_base]) begin
          prog_n = {1'b0, prog_base} + END_POS_W'(1);
        end else begin
          prog_n = (in_data_q == END_MARK[0]) ? END_POS_W'(1) : '0;
        end
        hdr_prog_d = prog_n[END_POS_W-2:0];
        if (prog_n == END_POS_W'(END_MARK_LEN)) begin
          hdr_prog_d = '0;
          hdr_done_d = 1'b1;
          if (!sel_chunked && sel_len == '0) done_d = 1'b1;
        end
      end else begin
        if (body_d != '1) body_d = body_d + LENGTH_BITS'(1);
        if (sel_chunked) begin
          if (term_d < TERM_POS_W'(CHUNK_END_LEN) && in_data_q == CHUNK_END[term_d]) begin
            term_n = term_d + TERM_POS_W'(1);
          end else begin
            term_n = (in_data_q == CHUNK_END[0]) ? TERM_POS_W'(1) : '0;
          end
          term_d = term_n;
          if (term_n == TERM_POS_W'(CHUNK_END_LEN)) begin
            term_d = '0;
            done_d = 1'b1;
          end
        end else if (body_d >= sel_len) begin
          done_d = 1'b1;
        end
      end
    end
  end

  assign out_len  = (hdr_done_d && !sel_chunked) ? sel_len : '0;
  assign len_ext  = {32'b0, out_len};
  assign body_ext = {32'b0, body_d};

  always_comb begin
    out_valid_d = out_valid_q;
    if (consume) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      hdr_prog_q  <= '0;
      hdr_done_q  <= 1'b0;
      body_q      <= '0;
      term_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      hdr_prog_q  <= hdr_prog_d;
      hdr_done_q  <= hdr_done_d;
      body_q      <= body_d;
      term_q      <= term_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_data_q <= s_axis_tdata_i;
      in_new_q  <= s_axis_tuser_i;
    end
    if (consume) begin
      out_data_q <= {body_ext[31:0], len_ext[31:0], hdr_done_d && sel_chunked,
                     done_d, hdr_done_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_data_q};

endmodule

// File: sv/hrcd_checker.sv
// ----------------------------------------------------------------------------
// hrcd_checker
// Port-level checks for the HTTP request completion detector.
// ----------------------------------------------------------------------------
module hrcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // completion only after header end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> m_axis_tdata_o[0])
    else $error("request complete without header end");

  // input side never blocked by an empty output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // a byte taken while the output is empty shows a valid result from the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> ##1 m_axis_tvalid_o)
    else $error("result missing after transfer");

endmodule

bind http_request_completion_detector hrcd_checker u_hrcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams request bytes into http_request_completion_detector with random
// bursts and gaps on the input and random stalls on the output, including one
// long output hold-off. A byte-level tracker of header end, length and
// encoding lines, body count and chunk terminator predicts each result word not given
// by a directed row; every expected word is compared field by field with the block's.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrcd_pkg::*;

  typedef struct packed {
    logic [4:0]  padding;
    logic [31:0] body_count;
    logic [31:0] declared_length;
    logic        chunked_mode;
    logic        request_complete;
    logic        headers_complete;
  } result_t;

  typedef struct packed {
    logic       fresh;
    logic [7:0] data;
  } req_byte_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        new_request;
    logic        typed;
    logic        headers_complete;
    logic        request_complete;
    logic [31:0] declared_length;
    logic [31:0] body_count;
  } row_t;

  localparam int unsigned DIRECTED_ROWS = 17;
  localparam int unsigned RANDOM_BYTES  = 1250;
  localparam int unsigned LEN_VARIANTS  = 13;
  localparam int unsigned ENC_VARIANTS  = 6;

  // typed rows carry their result, the rest go through the tracker
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h47, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_CR, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_LF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_CR, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_LF, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0},  // no length: done at header end
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 32'd1},  // bytes after completion
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 32'd2},
    '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},  // new request clears all
    '{CH_CR, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_CR, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_CR, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CH_CR, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;  // [7:0] data_byte
  logic        s_axis_tuser_i = 1'b0;   // [0] new_request
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;          // [0] headers_complete, [1] request_complete,
                                        // [2] chunked_mode, [34:3] declared_length,
                                        // [66:35] body_count, [71:67] zero

  result_t     results_due[$];
  req_byte_t   request_stream[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  logic        pending_fresh = 1'b0;
  int unsigned len_variant_count = 0;
  int unsigned enc_variant_count = 0;

  // tracker state
  int unsigned end_pos;
  int unsigned term_pos;
  logic        headers_seen;
  logic        done_flag;
  logic [31:0] body_bytes;
  int unsigned len_name_pos [2];
  logic        len_found [2];
  hrcd_phase_e len_phase [2];
  logic [31:0] len_value [2];
  logic        len_cr [2];
  int unsigned enc_name_pos [2];
  logic        enc_found [2];
  logic        enc_open [2];
  int unsigned word_pos [2];
  logic        enc_chunked [2];
  logic        enc_cr [2];

  http_request_completion_detector uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned step_match(int unsigned pos, int unsigned plen,
                                             logic [7:0] at_pos, logic [7:0] first,
                                             logic [7:0] b);
    if (pos < plen && b == at_pos) return pos + 1;
    return (b == first) ? 1 : 0;
  endfunction

  function automatic logic [7:0] len_name_char(int k, int unsigned idx);
    return (k == 0) ? UPPER_LEN_NAME[idx % LEN_NAME_LEN] : LOWER_LEN_NAME[idx % LEN_NAME_LEN];
  endfunction

  function automatic logic [7:0] enc_name_char(int k, int unsigned idx);
    return (k == 0) ? UPPER_ENC_NAME[idx % ENC_NAME_LEN] : LOWER_ENC_NAME[idx % ENC_NAME_LEN];
  endfunction

  // capitalised spelling wins over lowercase
  function automatic logic chosen_chunked();
    if (enc_found[0]) return enc_chunked[0];
    if (enc_found[1]) return enc_chunked[1];
    return 1'b0;
  endfunction

  function automatic logic [31:0] chosen_length();
    if (len_found[0]) return len_value[0];
    if (len_found[1]) return len_value[1];
    return 32'd0;
  endfunction

  task automatic clear_tracker();
    end_pos = 0;
    term_pos = 0;
    headers_seen = 1'b0;
    done_flag = 1'b0;
    body_bytes = '0;
    for (int k = 0; k < 2; k++) begin
      len_name_pos[k] = 0;
      len_found[k] = 1'b0;
      len_phase[k] = PH_IDLE;
      len_value[k] = '0;
      len_cr[k] = 1'b0;
      enc_name_pos[k] = 0;
      enc_found[k] = 1'b0;
      enc_open[k] = 1'b0;
      word_pos[k] = 0;
      enc_chunked[k] = 1'b0;
      enc_cr[k] = 1'b0;
    end
  endtask

  task automatic scan_length(input int k, input logic [7:0] b);
    logic [31:0] digit;
    if (!len_found[k]) begin
      len_name_pos[k] = step_match(len_name_pos[k], LEN_NAME_LEN,
                                   len_name_char(k, len_name_pos[k]), len_name_char(k, 0), b);
      if (len_name_pos[k] == LEN_NAME_LEN) begin
        len_found[k] = 1'b1;
        len_phase[k] = PH_LEAD;
        len_value[k] = '0;
      end
      return;
    end
    if (len_phase[k] == PH_DONE) return;
    if (len_cr[k]) begin
      len_cr[k] = 1'b0;
      if (b == CH_LF) begin
        if (len_phase[k] != PH_DIGITS && len_phase[k] != PH_TRAIL) len_value[k] = '0;
        len_phase[k] = PH_DONE;
        return;
      end
      len_phase[k] = PH_INVALID;
    end
    if (b == CH_CR) begin
      len_cr[k] = 1'b1;
    end else if (b == CH_SP || b == CH_TAB) begin
      if (len_phase[k] == PH_DIGITS) len_phase[k] = PH_TRAIL;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      if (len_phase[k] == PH_LEAD || len_phase[k] == PH_DIGITS) begin
        digit = {24'd0, b - CH_ZERO};
        len_phase[k] = PH_DIGITS;
        if (len_value[k] > (32'hFFFF_FFFF - digit) / 32'd10) begin
          len_value[k] = '1;
        end else begin
          len_value[k] = len_value[k] * 32'd10 + digit;
        end
      end else begin
        len_phase[k] = PH_INVALID;
      end
    end else begin
      len_phase[k] = PH_INVALID;
    end
  endtask

  task automatic scan_encoding(input int k, input logic [7:0] b);
    if (!enc_found[k]) begin
      enc_name_pos[k] = step_match(enc_name_pos[k], ENC_NAME_LEN,
                                   enc_name_char(k, enc_name_pos[k]), enc_name_char(k, 0), b);
      if (enc_name_pos[k] == ENC_NAME_LEN) begin
        enc_found[k] = 1'b1;
        enc_open[k] = 1'b1;
      end
      return;
    end
    if (!enc_open[k]) return;
    if (enc_cr[k]) begin
      enc_cr[k] = 1'b0;
      if (b == CH_LF) begin
        enc_open[k] = 1'b0;
        return;
      end
    end
    if (b == CH_CR) begin
      enc_cr[k] = 1'b1;
      word_pos[k] = 0;
      return;
    end
    word_pos[k] = step_match(word_pos[k], CHUNK_WORD_LEN,
                             CHUNK_WORD[word_pos[k] % CHUNK_WORD_LEN], CHUNK_WORD[0], b);
    if (word_pos[k] == CHUNK_WORD_LEN) begin
      enc_chunked[k] = 1'b1;
      word_pos[k] = 0;
    end
  endtask

  task automatic track_byte(input logic [7:0] b, input logic fresh, output result_t r);
    logic chunked;
    if (fresh) clear_tracker();
    if (!headers_seen) begin
      for (int k = 0; k < 2; k++) begin
        scan_length(k, b);
        scan_encoding(k, b);
      end
      end_pos = step_match(end_pos, END_MARK_LEN, END_MARK[end_pos % END_MARK_LEN],
                           END_MARK[0], b);
      if (end_pos == END_MARK_LEN) begin
        end_pos = 0;
        headers_seen = 1'b1;
        if (!chosen_chunked() && chosen_length() == 0) done_flag = 1'b1;
      end
    end else begin
      if (body_bytes != '1) body_bytes++;
      if (chosen_chunked()) begin
        term_pos = step_match(term_pos, CHUNK_END_LEN, CHUNK_END[term_pos % CHUNK_END_LEN],
                              CHUNK_END[0], b);
        if (term_pos == CHUNK_END_LEN) begin
          term_pos = 0;
          done_flag = 1'b1;
        end
      end else if (body_bytes >= chosen_length()) begin
        done_flag = 1'b1;
      end
    end
    chunked = headers_seen && chosen_chunked();
    r.padding = '0;
    r.body_count = body_bytes;
    r.declared_length = (headers_seen && !chunked) ? chosen_length() : 32'd0;
    r.chunked_mode = chunked;
    r.request_complete = done_flag;
    r.headers_complete = headers_seen;
  endtask

  // --- request generation ---------------------------------------------------

  task automatic put_byte(input logic [7:0] b);
    request_stream.push_back({pending_fresh, b});
    pending_fresh = 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_eol();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic put_length_line(input string name);
    int unsigned v;
    v = (len_variant_count < LEN_VARIANTS) ? len_variant_count
                                           : $urandom_range(0, LEN_VARIANTS - 1);
    len_variant_count++;
    put_text(name);
    case (v)
      0: put_text($sformatf(" %0d", $urandom_range(0, 24)));
      1: begin
        put_byte(CH_TAB);
        put_byte(CH_SP);
        put_text($sformatf("%0d", $urandom_range(1, 24)));
        put_byte(CH_SP);
        put_byte(CH_TAB);
      end
      2: ;
      3: put_text(" +5");
      4: put_text(" 1 2");
      5: begin
        put_text(" 1");
        put_byte(CH_CR);
        put_text("2");
      end
      6: put_text(" 12a");
      7: put_text(" 4294967295");
      8: put_text(" 4294967296");
      9: put_text(" 99999999999999999999");
      10: put_text(" 0");
      11: put_text(" 0003");
      default: put_text("  ");
    endcase
    put_eol();
  endtask

  task automatic put_encoding_line(input string name, inout logic chunky);
    int unsigned v;
    v = (enc_variant_count < ENC_VARIANTS) ? enc_variant_count
                                           : $urandom_range(0, ENC_VARIANTS - 1);
    enc_variant_count++;
    put_text(name);
    case (v)
      0: put_text(" chunked");
      1: put_text(" gzip, chunked");
      2: put_text(" gzip");
      3: put_text(" chunkchunked");
      4: begin
        put_text(" chun");
        put_byte(CH_CR);
        put_text("ked");
      end
      default: put_text(" identity");
    endcase
    if (v == 0 || v == 1 || v == 3) chunky = 1'b1;
    put_eol();
  endtask

  task automatic put_header(inout logic chunky);
    int unsigned kind;
    kind = $urandom_range(0, 11);
    if (kind > 8) kind -= 9;
    case (kind)
      0: put_length_line("Content-Length:");
      1: put_length_line("content-length:");
      2: put_encoding_line("Transfer-Encoding:", chunky);
      3: put_encoding_line("transfer-encoding:", chunky);
      4: begin
        case ($urandom_range(0, 3))
          0: put_text("Content-length: 4");
          1: put_text("CONTENT-LENGTH: 4");
          2: put_text("Content-Length 4");
          default: put_text("Transfer-encoding: chunked");
        endcase
        put_eol();
      end
      5: begin
        put_text("Host: h");
        put_eol();
      end
      6: begin
        repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
        put_eol();
      end
      7: begin
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
        put_eol();
      end
      default: begin
        put_length_line("content-length:");
        put_length_line("Content-Length:");
      end
    endcase
  endtask

  task automatic build_request();
    logic chunky;
    chunky = 1'b0;
    pending_fresh = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        pending_fresh = ($urandom_range(0, 7) == 0);
        put_byte(8'($urandom_range(0, 255)));
      end
      return;
    end
    put_text(($urandom_range(0, 1) != 0) ? "GET /" : "POST /a");
    put_eol();
    repeat ($urandom_range(0, 4)) put_header(chunky);
    put_eol();
    if (chunky && $urandom_range(0, 4) != 0) begin
      repeat ($urandom_range(0, 2)) begin
        put_text("3");
        put_eol();
        put_text("a0b");
        put_eol();
      end
      if ($urandom_range(0, 2) == 0) begin
        // terminator broken off one byte short
        put_text("0");
        put_eol();
        put_byte(CH_CR);
        put_text("x");
      end
      put_text("0");
      put_eol();
      put_eol();
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 5) == 0) begin
        put_text("Content-Length: 1");
        put_eol();
      end
      repeat ($urandom_range(0, 16)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // --- driving and checking ---------------------------------------------------

  task automatic offer_byte(input logic [7:0] b, input logic fresh,
                            input logic typed, input result_t typed_result);
    result_t predicted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tuser_i <= fresh;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_byte(b, fresh, predicted);
    results_due.push_back(typed ? typed_result : predicted);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        compare_field("headers_complete", 32'(want.headers_complete), 32'(got.headers_complete));
        compare_field("request_complete", 32'(want.request_complete), 32'(got.request_complete));
        compare_field("chunked_mode", 32'(want.chunked_mode), 32'(got.chunked_mode));
        compare_field("declared_length", want.declared_length, got.declared_length);
        compare_field("body_count", want.body_count, got.body_count);
        compare_field("padding", 32'(want.padding), 32'(got.padding));
      end
    end
  end

  initial begin : output_pacing
    logic held_off;
    int unsigned mode;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 9);
      if (!held_off && results_seen > 300) begin
        // long hold-off so the input side backs up
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (mode < 4) begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else if (mode < 8) begin
        repeat ($urandom_range(10, 60)) begin
          m_axis_tready_i <= ($urandom_range(0, 1) != 0);
          @(posedge clk_i);
        end
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : run_limit
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    result_t   typed_result;
    req_byte_t next_byte;
    clear_tracker();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      typed_result = '0;
      typed_result.headers_complete = DIRECTED[i].headers_complete;
      typed_result.request_complete = DIRECTED[i].request_complete;
      typed_result.declared_length = DIRECTED[i].declared_length;
      typed_result.body_count = DIRECTED[i].body_count;
      offer_byte(DIRECTED[i].data_byte, DIRECTED[i].new_request, DIRECTED[i].typed,
                 typed_result);
    end

    while (request_stream.size() < RANDOM_BYTES) build_request();
    typed_result = '0;
    while (request_stream.size() != 0) begin
      next_byte = request_stream.pop_front();
      offer_byte(next_byte.data, next_byte.fresh, 1'b0, typed_result);
    end
    s_axis_tvalid_i <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
